// ===== hw/rtl/voxel_ray_traversal_top_defines.svh =====
// Assertion macros for the voxel ray walker.
`ifndef VOXEL_RAY_TRAVERSAL_TOP_DEFINES_SVH
`define VOXEL_RAY_TRAVERSAL_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define VRT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define VRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/vrt_pkg.sv =====
package vrt_pkg;

    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 48;
    localparam int DIST_W    = 32;
    localparam int DIR_W     = 16;
    localparam int ORG_W     = 32;
    localparam int CELL_W    = 16;
    localparam int MAXD_W    = 24;

    localparam logic [MAXD_W-1:0] MAX_DIST_RESET = 24'h080000;

    localparam logic MODE_START  = 1'b0;
    localparam logic MODE_ANSWER = 1'b1;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;

    typedef struct packed {
        logic             start;
        logic [DIR_W-1:0] mag;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== hw/rtl/vrt_recip.sv =====
module vrt_recip #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vrt_pkg::t_div_req i_req,
    output vrt_pkg::t_div_rsp o_rsp
);

    localparam int QW = FRAC_BITS + 16;
    localparam int CW = $clog2(QW + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CW-1:0]               r_cnt;
    logic [vrt_pkg::DIR_W-1:0]   r_mag;
    logic [vrt_pkg::DIR_W-1:0]   r_rem;
    logic [QW-1:0]               r_quot;

    logic                        n_bit;
    logic [vrt_pkg::DIR_W:0]     n_trial;
    logic [vrt_pkg::DIR_W:0]     n_diff;
    logic                        n_fit;
    logic [vrt_pkg::DIR_W-1:0]   n_rem;
    logic [63:0]                 n_qext;

    always_comb begin
        n_bit   = (r_cnt == CW'(QW));
        n_trial = {r_rem, n_bit};
        n_diff  = n_trial - {1'b0, r_mag};
        n_fit   = (n_trial >= {1'b0, r_mag});
        n_rem   = n_fit ? n_diff[vrt_pkg::DIR_W-1:0] : n_trial[vrt_pkg::DIR_W-1:0];
        n_qext  = 64'(r_quot);
        o_rsp.done = r_done;
        o_rsp.quot = (|n_qext[63:32]) ? '1 : n_qext[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
                r_mag  <= i_req.mag;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_quot <= {r_quot[QW-2:0], n_fit};
                r_cnt  <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/voxel_ray_traversal_top.sv =====
// Voxel ray walker (3D grid DDA, Q16.16 distances). A start transaction (tuser 0)
// loads a ray; the block works out the three per-axis step lengths with one shared
// restoring divider, one quotient bit a cycle, then takes the first step and returns
// a query, or a miss once the ray passes max_distance. An answer transaction
// (tuser 1) returns a hit for an occupied cell, a miss when no ray is loaded, else
// the next step. For a start, each axis passes prep, divide (FRAC_BITS+16 quotient
// bits; a zero direction axis skips the divider), multiply and side states; a start
// and an answer that steps then select the axis, step and load the output register,
// and a hit or an answer with no ray loads it directly. A result still waiting in the
// output register delays the load. The input side is not ready while an item is in
// work and opens again as the result is loaded.
module voxel_ray_traversal_top #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, occupied, zero pad
    input  logic [vrt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // mode
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // cell_x, cell_y, cell_z
    output logic [vrt_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // kind
    output logic [1:0]                      m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vrt_pkg::MAXD_W-1:0]      i_cfg_data
);

    localparam int DW = FRAC_BITS + 1;
    localparam int PW = DW + vrt_pkg::DIST_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MUL,
        ST_SIDE,
        ST_SEL,
        ST_STEP,
        ST_EMIT
    } t_state;

    t_state                        r_state;
    logic                          r_active;
    logic [1:0]                    r_axis;
    logic [1:0]                    r_sel;
    logic [1:0]                    r_kind;
    logic [vrt_pkg::MAXD_W-1:0]    r_max_dist;
    logic [COORD_BITS-1:0]         r_cell     [3];
    logic [vrt_pkg::DIST_W-1:0]    r_side     [3];
    logic [vrt_pkg::DIST_W-1:0]    r_delta    [3];
    logic                          r_step_neg [3];
    logic [FRAC_BITS-1:0]          r_frac     [3];
    logic [vrt_pkg::DIR_W-1:0]     r_mag      [3];
    logic [PW-1:0]                 r_prod;
    vrt_pkg::t_div_req             r_div_req;
    vrt_pkg::t_div_rsp             div_rsp;

    logic [vrt_pkg::ORG_W-1:0]     n_org [3];
    logic [vrt_pkg::DIR_W-1:0]     n_dir [3];
    logic                          n_occupied;
    logic [DW-1:0]                 n_dist;
    logic [1:0]                    n_sel;
    logic [vrt_pkg::DIST_W:0]      n_sum;
    logic [vrt_pkg::DIST_W-1:0]    n_side_new;
    logic                          n_in_range;
    logic [COORD_BITS-1:0]         n_cell_new;

    vrt_recip #(
        .FRAC_BITS (FRAC_BITS)
    ) u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_org[a] = s_axis_tdata[a*vrt_pkg::ORG_W +: vrt_pkg::ORG_W];
            n_dir[a] = s_axis_tdata[3*vrt_pkg::ORG_W + a*vrt_pkg::DIR_W +: vrt_pkg::DIR_W];
        end
        n_occupied = s_axis_tdata[3*vrt_pkg::ORG_W + 3*vrt_pkg::DIR_W];

        n_dist = r_step_neg[r_axis] ? {1'b0, r_frac[r_axis]}
                                    : (DW'(1) << FRAC_BITS) - {1'b0, r_frac[r_axis]};

        if (r_side[0] <= r_side[1] && r_side[0] <= r_side[2]) begin
            n_sel = 2'd0;
        end else if (r_side[1] <= r_side[0] && r_side[1] <= r_side[2]) begin
            n_sel = 2'd1;
        end else begin
            n_sel = 2'd2;
        end

        n_sum      = {1'b0, r_side[r_sel]} + {1'b0, r_delta[r_sel]};
        n_side_new = n_sum[vrt_pkg::DIST_W] ? '1 : n_sum[vrt_pkg::DIST_W-1:0];
        n_in_range = (r_side[r_sel] <= vrt_pkg::DIST_W'(r_max_dist));
        n_cell_new = r_step_neg[r_sel] ? r_cell[r_sel] - COORD_BITS'(1)
                                       : r_cell[r_sel] + COORD_BITS'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_active        <= 1'b0;
            r_axis          <= 2'd0;
            r_max_dist      <= vrt_pkg::MAX_DIST_RESET;
            r_div_req.start <= 1'b0;
            m_axis_tvalid   <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;
            if (i_cfg_valid) begin
                r_max_dist <= i_cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        if (s_axis_tuser == vrt_pkg::MODE_START) begin
                            for (int a = 0; a < 3; a++) begin
                                r_cell[a]     <= COORD_BITS'($signed(n_org[a]) >>> FRAC_BITS);
                                r_frac[a]     <= n_org[a][FRAC_BITS-1:0];
                                r_step_neg[a] <= n_dir[a][vrt_pkg::DIR_W-1];
                                r_mag[a]      <= n_dir[a][vrt_pkg::DIR_W-1] ? (~n_dir[a] + 1'b1)
                                                                            : n_dir[a];
                            end
                            r_active <= 1'b1;
                            r_axis   <= 2'd0;
                            r_state  <= ST_PREP;
                        end else if (!r_active) begin
                            r_kind  <= vrt_pkg::KIND_MISS;
                            r_state <= ST_EMIT;
                        end else if (n_occupied) begin
                            r_active <= 1'b0;
                            r_kind   <= vrt_pkg::KIND_HIT;
                            r_state  <= ST_EMIT;
                        end else begin
                            r_state <= ST_SEL;
                        end
                    end
                end
                ST_PREP: begin
                    if (r_mag[r_axis] == '0) begin
                        r_delta[r_axis] <= '1;
                        r_state         <= ST_MUL;
                    end else begin
                        r_div_req.start <= 1'b1;
                        r_div_req.mag   <= r_mag[r_axis];
                        r_state         <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_delta[r_axis] <= div_rsp.quot;
                        r_state         <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_prod  <= PW'(n_dist) * PW'(r_delta[r_axis]);
                    r_state <= ST_SIDE;
                end
                ST_SIDE: begin
                    r_side[r_axis] <= r_prod[FRAC_BITS +: vrt_pkg::DIST_W];
                    if (r_axis == 2'd2) begin
                        r_state <= ST_SEL;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= ST_PREP;
                    end
                end
                ST_SEL: begin
                    r_sel   <= n_sel;
                    r_state <= ST_STEP;
                end
                ST_STEP: begin
                    r_cell[r_sel] <= n_cell_new;
                    r_side[r_sel] <= n_side_new;
                    if (n_in_range) begin
                        r_kind <= vrt_pkg::KIND_QUERY;
                    end else begin
                        r_active <= 1'b0;
                        r_kind   <= vrt_pkg::KIND_MISS;
                    end
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!m_axis_tvalid || m_axis_tready) begin
                        m_axis_tvalid <= 1'b1;
                        m_axis_tuser  <= r_kind;
                        if (r_kind == vrt_pkg::KIND_MISS) begin
                            m_axis_tdata <= '0;
                        end else begin
                            m_axis_tdata <= {vrt_pkg::CELL_W'(r_cell[2]),
                                             vrt_pkg::CELL_W'(r_cell[1]),
                                             vrt_pkg::CELL_W'(r_cell[0])};
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/vrt_check.sv =====
`include "voxel_ray_traversal_top_defines.svh"

module vrt_check (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [vrt_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]                    m_axis_tuser
);

    logic                          in_xfer;
    logic                          out_stall;
    logic                          kind_ok;
    logic                          miss_out;
    logic [vrt_pkg::M_TDATA_W+1:0] out_word;

    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign kind_ok   = (m_axis_tuser == vrt_pkg::KIND_QUERY) ||
                       (m_axis_tuser == vrt_pkg::KIND_HIT) ||
                       (m_axis_tuser == vrt_pkg::KIND_MISS);
    assign miss_out  = m_axis_tvalid && (m_axis_tuser == vrt_pkg::KIND_MISS);
    assign out_word  = {m_axis_tuser, m_axis_tdata};

    `VRT_ASSERT(a_out_hold, i_clk, i_rst_n, out_stall |=> m_axis_tvalid, "result dropped")
    `VRT_ASSERT(a_out_stable, i_clk, i_rst_n, out_stall |=> $stable(out_word), "result changed")
    `VRT_ASSERT(a_kind_legal, i_clk, i_rst_n, m_axis_tvalid |-> kind_ok, "illegal result kind")
    `VRT_ASSERT(a_miss_zero, i_clk, i_rst_n, miss_out |-> m_axis_tdata == '0, "miss with cell")
    `VRT_ASSERT(a_busy_after_in, i_clk, i_rst_n, in_xfer |=> !s_axis_tready, "ready after input")

endmodule

bind voxel_ray_traversal_top vrt_check u_vrt_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
